// ----- hdl/lpq_pkg.sv -----
`default_nettype none

package lpq_pkg;

    localparam int STAMP_W     = 32;
    localparam int HALF_KEY_W  = 16;
    localparam int IN_ENTRY_W  = 32;
    localparam int OUT_ENTRY_W = 32;
    localparam int HELD_W      = 7;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } lpq_state_t;

    typedef struct packed {
        logic clear;
        logic sample;
        logic remove;
    } best_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/lpq_slot_ram.sv -----
`default_nettype none

module lpq_slot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 97
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hdl/lpq_best_unit.sv -----
`default_nettype none

module lpq_best_unit
    import lpq_pkg::*;
#(
    parameter int ADDR_W  = 6,
    parameter int KEY2_W  = 32,
    parameter int ENTRY_W = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire best_ctrl_t         ctrl,
    input  wire logic               cand_valid,
    input  wire logic [KEY2_W-1:0]  cand_key,
    input  wire logic [STAMP_W-1:0] cand_stamp,
    input  wire logic [ENTRY_W-1:0] cand_entry,
    input  wire logic [ADDR_W-1:0]  cand_addr,
    input  wire logic [STAMP_W-1:0] arrival,
    output logic                    have,
    output logic      [ADDR_W-1:0]  best_addr,
    output logic      [ENTRY_W-1:0] best_entry
);

    logic               have_reg;
    logic [ADDR_W-1:0]  best_addr_reg;
    logic [KEY2_W-1:0]  best_key_reg;
    logic [STAMP_W-1:0] best_age_reg;
    logic [ENTRY_W-1:0] best_entry_reg;
    logic [STAMP_W-1:0] cand_age;
    logic               take;

    always_comb
    begin
        cand_age = arrival - cand_stamp;
        if (ctrl.remove)
        begin
            take = cand_valid && (!have_reg || (cand_key < best_key_reg) ||
                   ((cand_key == best_key_reg) && (cand_age > best_age_reg)));
        end
        else
        begin
            take = !cand_valid && !have_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            have_reg <= 1'b0;
        end
        else if (ctrl.sample && take)
        begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctrl.clear && ctrl.sample && take)
        begin
            best_addr_reg  <= cand_addr;
            best_key_reg   <= cand_key;
            best_age_reg   <= cand_age;
            best_entry_reg <= cand_entry;
        end
    end

    assign have       = have_reg;
    assign best_addr  = best_addr_reg;
    assign best_entry = best_entry_reg;

endmodule

`default_nettype wire

// ----- hdl/lexicographic_priority_queue_fifo.sv -----
// An insert or a remove that scans goes through ST_SCAN, reading every slot, then
// ST_DRAIN and ST_COMMIT; a dropped insert or a remove from an empty store goes
// straight to ST_COMMIT, which waits until the output register is free.
// A new item is taken only in ST_IDLE, once the last one has committed. The scan
// reads the single-read-port slot RAM one slot per cycle into one shared compare unit.
// Reset: asynchronous; then a clearing pass writes every slot empty, with in_ready low.
`default_nettype none

module lexicographic_priority_queue_fifo
    import lpq_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int KEY_WIDTH   = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   kind,
    input  wire logic [HALF_KEY_W-1:0]  key_first,
    input  wire logic [HALF_KEY_W-1:0]  key_second,
    input  wire logic [IN_ENTRY_W-1:0]  entry_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [OUT_ENTRY_W-1:0] out_entry,
    output logic                        found,
    output logic                        full_drop,
    output logic      [HELD_W-1:0]      held_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int KEY2_W = 2 * KEY_WIDTH;
    localparam int WORD_W = 1 + KEY2_W + STAMP_W + ENTRY_WIDTH;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);

    lpq_state_t state_reg, state_next;

    logic [ADDR_W-1:0]      scan_addr_reg, scan_addr_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [ADDR_W-1:0]      rd_addr_reg;
    logic                   kind_reg;
    logic [KEY2_W-1:0]      key_reg;
    logic [ENTRY_WIDTH-1:0] entry_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [STAMP_W-1:0]     arrival_reg, arrival_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_ENTRY_W-1:0] out_entry_reg, out_entry_next;
    logic                   found_reg, found_next;
    logic                   drop_reg, drop_next;
    logic [HELD_W-1:0]      held_reg, held_next;

    logic                   accept;
    logic                   out_free;
    logic                   full;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic                   ram_re;
    logic [WORD_W-1:0]      ram_rdata;
    best_ctrl_t             best_ctrl;
    logic                   best_have;
    logic [ADDR_W-1:0]      best_addr;
    logic [ENTRY_WIDTH-1:0] best_entry;

    logic [KEY_WIDTH+HALF_KEY_W-1:0]   key_first_ext;
    logic [KEY_WIDTH+HALF_KEY_W-1:0]   key_second_ext;
    logic [ENTRY_WIDTH+IN_ENTRY_W-1:0] entry_in_ext;
    logic [ENTRY_WIDTH+OUT_ENTRY_W-1:0] best_entry_ext;
    logic [CNT_W+HELD_W-1:0]           count_ext;

    assign key_first_ext  = {KEY_WIDTH'(0), key_first};
    assign key_second_ext = {KEY_WIDTH'(0), key_second};
    assign entry_in_ext   = {ENTRY_WIDTH'(0), entry_data};
    assign best_entry_ext = {OUT_ENTRY_W'(0), best_entry};

    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign full     = (count_reg == FULL_CNT);

    lpq_slot_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (scan_addr_reg),
        .rdata (ram_rdata)
    );

    lpq_best_unit #(
        .ADDR_W  (ADDR_W),
        .KEY2_W  (KEY2_W),
        .ENTRY_W (ENTRY_WIDTH)
    ) u_best_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (best_ctrl),
        .cand_valid (ram_rdata[WORD_W-1]),
        .cand_key   (ram_rdata[WORD_W-2 -: KEY2_W]),
        .cand_stamp (ram_rdata[ENTRY_WIDTH +: STAMP_W]),
        .cand_entry (ram_rdata[ENTRY_WIDTH-1:0]),
        .cand_addr  (rd_addr_reg),
        .arrival    (arrival_reg),
        .have       (best_have),
        .best_addr  (best_addr),
        .best_entry (best_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            count_reg     <= '0;
            arrival_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg   <= rd_pend_next;
            count_reg     <= count_next;
            arrival_reg   <= arrival_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg   <= scan_addr_reg;
        out_entry_reg <= out_entry_next;
        found_reg     <= found_next;
        drop_reg      <= drop_next;
        held_reg      <= held_next;
        if (accept)
        begin
            kind_reg  <= kind;
            key_reg   <= {key_first_ext[KEY_WIDTH-1:0], key_second_ext[KEY_WIDTH-1:0]};
            entry_reg <= entry_in_ext[ENTRY_WIDTH-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        scan_addr_next   = scan_addr_reg;
        rd_pend_next     = 1'b0;
        count_next       = count_reg;
        arrival_next     = arrival_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_entry_next   = out_entry_reg;
        found_next       = found_reg;
        drop_next        = drop_reg;
        held_next        = held_reg;
        in_ready         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = scan_addr_reg;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        best_ctrl.clear  = 1'b0;
        best_ctrl.sample = rd_pend_reg;
        best_ctrl.remove = (kind_reg == KIND_REMOVE);
        count_ext        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (scan_addr_reg == LAST_ADDR)
                begin
                    scan_addr_next = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    best_ctrl.clear = 1'b1;
                    scan_addr_next  = '0;
                    if (((kind == KIND_INSERT) && full) ||
                        ((kind == KIND_REMOVE) && (count_reg == '0)))
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                ram_re       = 1'b1;
                rd_pend_next = 1'b1;
                if (scan_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = '0;
                    found_next     = 1'b0;
                    drop_next      = 1'b0;
                    ram_waddr      = best_addr;
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (full || !best_have)
                        begin
                            drop_next = 1'b1;
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            ram_wdata    = {1'b1, key_reg, arrival_reg, entry_reg};
                            count_next   = count_reg + CNT_W'(1);
                            arrival_next = arrival_reg + STAMP_W'(1);
                        end
                    end
                    else if (best_have)
                    begin
                        ram_we         = 1'b1;
                        found_next     = 1'b1;
                        out_entry_next = best_entry_ext[OUT_ENTRY_W-1:0];
                        count_next     = count_reg - CNT_W'(1);
                    end
                    count_ext  = {HELD_W'(0), count_next};
                    held_next  = count_ext[HELD_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_entry  = out_entry_reg;
    assign found      = found_reg;
    assign full_drop  = drop_reg;
    assign held_count = held_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("entry count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) && (kind_reg == KIND_INSERT) && !full |-> best_have)
        else $error("insert scan found no free slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) && out_free && (kind_reg == KIND_REMOVE) && best_have
        |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("remove did not decrement count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) && out_free && (kind_reg == KIND_REMOVE) && best_have
        |=> out_valid_reg && found_reg && !drop_reg)
        else $error("remove result flags wrong");

endmodule

`default_nettype wire
